/* rtl/timestamp_difference_core_macros.svh */
// Assertion macros shared by the timestamp difference RTL.
`ifndef TIMESTAMP_DIFFERENCE_CORE_MACROS_SVH
`define TIMESTAMP_DIFFERENCE_CORE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define TSD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger implies a condition at the same edge.
`define TSD_ASSERT_IMP(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Check that a trigger implies a condition at the next edge.
`define TSD_ASSERT_NXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/tsd_pkg.sv */
// Types, constants and calendar functions of the timestamp difference block.
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;

  localparam int unsigned DaysW   = 16;  // day count of one timestamp
  localparam int unsigned ModW    = 11;  // hour * 60 + minute
  localparam int unsigned CountW  = 27;  // minute count of one timestamp
  localparam int unsigned QuotW   = 17;  // quotient estimate by 45

  localparam int unsigned NumStages = 6;

  localparam int unsigned MinPerDay  = 1440;
  localparam int unsigned MinPerHour = 60;

  // floor(2^28 / 45): divides (count >> 5) by 45, at most one short
  localparam int unsigned Recip45Shift = 28;
  localparam int unsigned Recip45      = (1 << Recip45Shift) / 45;
  // ceil-ish 2^16 / 60: exact quotient for values below 1440
  localparam int unsigned Recip60Shift = 16;
  localparam int unsigned Recip60      = 1093;

  typedef struct packed {
    logic [YearW-1:0]   start_year;
    logic [MonthW-1:0]  start_month;
    logic [DayW-1:0]    start_day;
    logic [HourW-1:0]   start_hour;
    logic [MinuteW-1:0] start_minute;
    logic [YearW-1:0]   stop_year;
    logic [MonthW-1:0]  stop_month;
    logic [DayW-1:0]    stop_day;
    logic [HourW-1:0]   stop_hour;
    logic [MinuteW-1:0] stop_minute;
  } tsd_in_t;

  typedef struct packed {
    logic [15:0] diff_days;
    logic [4:0]  diff_hours;
    logic [5:0]  diff_minutes;
  } tsd_out_t;

  // Per-stage load enables, stage 1 first.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } tsd_stage_en_t;

  // Days in years 1 .. y-1 under the Gregorian rule (y below 128).
  function automatic logic [DaysW-1:0] year_days(input logic [YearW-1:0] y);
    logic [YearW-1:0] n;
    logic [DaysW-1:0] acc;
    n   = (y == '0) ? '0 : YearW'(y - YearW'(1));
    acc = DaysW'(n) * DaysW'(365);
    acc = acc + DaysW'(n[YearW-1:2]);
    if (n >= YearW'(100)) begin
      acc = acc - DaysW'(1);
    end
    return acc;
  endfunction

  // Leap test for y below 128: only years 0 and 100 are multiples of 100.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != YearW'(100));
  endfunction

  // Days in the months before month m of a common year; 13..15 count a full year.
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd334 + 9'd31;
    endcase
    return d;
  endfunction

endpackage

/* rtl/tsd_count.sv */
// Two-stage conversion of one timestamp into a minute count.
`timescale 1ns / 1ps

module tsd_count import tsd_pkg::*; (
  input  logic                 clk_i,
  input  tsd_stage_en_t        en_i,
  input  logic [YearW-1:0]     year_i,
  input  logic [MonthW-1:0]    month_i,
  input  logic [DayW-1:0]      day_i,
  input  logic [HourW-1:0]     hour_i,
  input  logic [MinuteW-1:0]   minute_i,
  output logic [CountW-1:0]    count_o
);

  logic [DaysW-1:0]  days_d, days_q;
  logic [ModW-1:0]   mod_d, mod_q;
  logic [CountW-1:0] count_d, count_q;
  logic              leap_add;

  // Stage 1: table lookups, day count and minute of day.
  always_comb begin
    leap_add = (month_i >= MonthW'(3)) && is_leap(year_i);
    days_d   = year_days(year_i) + DaysW'(days_before_month(month_i))
             + DaysW'(leap_add) + DaysW'(day_i);
    mod_d    = ModW'(hour_i) * ModW'(MinPerHour) + ModW'(minute_i);
  end

  // Stage 2: scale days to minutes.
  assign count_d = CountW'(days_q) * CountW'(MinPerDay) + CountW'(mod_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      days_q <= days_d;
      mod_q  <= mod_d;
    end
    if (en_i.s2) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

/* rtl/tsd_split.sv */
// Three-stage split of a minute difference into days, hours and minutes.
`timescale 1ns / 1ps

module tsd_split import tsd_pkg::*; (
  input  logic                 clk_i,
  input  tsd_stage_en_t        en_i,
  input  logic [CountW-1:0]    diff_i,
  output tsd_out_t             result_o
);

  localparam int unsigned XW   = CountW - 5;            // diff / 32
  localparam int unsigned PW   = XW + 23;               // product width
  localparam int unsigned H60W = ModW + ModW;

  logic [XW-1:0]    x_q;
  logic [4:0]       low_q;
  logic [QuotW-1:0] q0_d, q0_q;
  logic [PW-1:0]    prod45;

  logic [XW-1:0]    r_full;
  logic [6:0]       r_raw;
  logic [5:0]       r_fix;
  logic [QuotW-1:0] q_d, q_q;
  logic [ModW-1:0]  rem_q;

  logic [H60W-1:0]  prod60;
  logic [4:0]       hours_d;
  logic [ModW-1:0]  mins_full;
  tsd_out_t         res_d, res_q;

  // Stage 4: 1440 = 32 * 45; estimate (diff >> 5) / 45 by reciprocal.
  assign prod45 = PW'(diff_i[CountW-1:5]) * PW'(Recip45);
  assign q0_d   = prod45[Recip45Shift +: QuotW];

  // Stage 5: correct the estimate by at most one.
  always_comb begin
    r_full = x_q - XW'(q0_q) * XW'(45);
    r_raw  = r_full[6:0];
    if (r_raw >= 7'd45) begin
      q_d   = q0_q + QuotW'(1);
      r_fix = 6'(r_raw - 7'd45);
    end else begin
      q_d   = q0_q;
      r_fix = r_raw[5:0];
    end
  end

  // Stage 6: minute of day into hours and minutes.
  always_comb begin
    prod60    = H60W'(rem_q) * H60W'(Recip60);
    hours_d   = prod60[Recip60Shift +: 5];
    mins_full = rem_q - ((ModW'(hours_d) << 6) - (ModW'(hours_d) << 2));
    res_d.diff_days    = q_q[15:0];
    res_d.diff_hours   = hours_d;
    res_d.diff_minutes = mins_full[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      x_q   <= diff_i[CountW-1:5];
      low_q <= diff_i[4:0];
      q0_q  <= q0_d;
    end
    if (en_i.s5) begin
      q_q   <= q_d;
      rem_q <= {r_fix, low_q};
    end
    if (en_i.s6) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

/* rtl/timestamp_difference_core.sv */
// Top level of the timestamp difference pipeline.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o | tsd_in_t: two timestamps
//  out     | output    | out_valid_o/out_stall_i | tsd_out_t: days/hours/minutes
//
//  Six register stages: lookups, scale to minutes, absolute difference,
//  reciprocal divide by 45, quotient correction, hour/minute split.
//  One word enters and one leaves every cycle while out_stall_i stays low.
//  Each stage is logic ahead of one register set; the multiplies of stages 2
//  and 4 and the stage-5 compare/correct are the deepest logic and bound the clock period.
//  Reset clears only the stage valid bits; data registers carry no reset.
//  Each stage loads when it is empty or the one after it moves, so bubbles
//  close up under a stall and in_stall_o rises only when all stages are full.

module timestamp_difference_core import tsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tsd_out_t out_data_o
);

`include "timestamp_difference_core_macros.svh"

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] load;
  tsd_stage_en_t        en;

  logic [CountW-1:0] start_cnt, stop_cnt;
  logic [CountW-1:0] diff_d, diff_q;

  // Load enables: walk back from the output stage.
  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign en = '{s1: load[0], s2: load[1], s3: load[2],
                s4: load[3], s5: load[4], s6: load[5]};

  // Advance valid bits with the data; hold a stage that cannot move.
  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stages 1 and 2, once for each timestamp.
  tsd_count u_start (
    .clk_i    (clk_i),
    .en_i     (en),
    .year_i   (in_data_i.start_year),
    .month_i  (in_data_i.start_month),
    .day_i    (in_data_i.start_day),
    .hour_i   (in_data_i.start_hour),
    .minute_i (in_data_i.start_minute),
    .count_o  (start_cnt)
  );

  tsd_count u_stop (
    .clk_i    (clk_i),
    .en_i     (en),
    .year_i   (in_data_i.stop_year),
    .month_i  (in_data_i.stop_month),
    .day_i    (in_data_i.stop_day),
    .hour_i   (in_data_i.stop_hour),
    .minute_i (in_data_i.stop_minute),
    .count_o  (stop_cnt)
  );

  // Stage 3: absolute difference of the two minute counts.
  assign diff_d = (stop_cnt >= start_cnt) ? (stop_cnt - start_cnt)
                                          : (start_cnt - stop_cnt);

  always_ff @(posedge clk_i) begin
    if (en.s3) begin
      diff_q <= diff_d;
    end
  end

  // Stages 4 to 6: divide by 1440 and 60.
  tsd_split u_split (
    .clk_i    (clk_i),
    .en_i     (en),
    .diff_i   (diff_q),
    .result_o (out_data_o)
  );

  assign out_valid_o = valid_q[NumStages-1];
  assign in_stall_o  = !load[0];

  // Stall the input only when every stage holds a word and the output is stalled.
  `TSD_ASSERT_IMP(a_stall_full, in_stall_o, (&valid_q) && out_stall_i, "stall with empty stage")
  // A word leaving stage 3 shows up in stage 4.
  `TSD_ASSERT_NXT(a_s3_moves, valid_q[2] && load[3], valid_q[3], "stage 3 word lost")
  // Split results stay in range.
  `TSD_ASSERT_IMP(a_split_range, out_valid_o,
                  (out_data_o.diff_hours < 5'd24) && (out_data_o.diff_minutes < 6'd60),
                  "hour or minute out of range")
  // An accepted word is in stage 1 at the next edge.
  `TSD_ASSERT_NXT(a_in_taken, in_valid_i && !in_stall_o, valid_q[0], "input word lost")

endmodule

/* tb/tb_timestamp_difference_core.sv */
// Self-checking testbench of the timestamp difference pipeline.
`timescale 1ns / 1ps

module tb_timestamp_difference_core;
  import tsd_pkg::*;

  localparam int unsigned RandomWords = 1000;
  localparam int unsigned HoldCycles  = 200;    // long receiver hold-off
  localparam int unsigned FillWords   = 40;     // words offered during the hold-off
  localparam int unsigned TailCycles  = 20;     // well past the six-stage latency
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PrintCap    = 50;

  // Predicts the day/hour/minute gap of each accepted word and checks results in order.
  class gap_scoreboard;
    tsd_out_t    pending_gaps[$];
    int unsigned mismatch_count = 0;

    // Minutes since the start of year 1, Gregorian leap rule, no range checks.
    function int unsigned stamp_minutes(logic [YearW-1:0] y, logic [MonthW-1:0] m,
                                        logic [DayW-1:0] d, logic [HourW-1:0] h,
                                        logic [MinuteW-1:0] mi);
      int unsigned n;
      int unsigned days;
      n    = (y == 0) ? 0 : y - 1;
      days = 365 * n + n / 4 - n / 100 + n / 400;
      // Sum the months ahead of this one; months past twelve count the whole year.
      for (int k = 1; k < m && k <= 12; k++) begin
        days += (k == 2) ? 28 : (k == 4 || k == 6 || k == 9 || k == 11) ? 30 : 31;
      end
      if (m >= 3 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) begin
        days++;
      end
      days += d;
      return days * MinPerDay + h * MinPerHour + mi;
    endfunction

    function tsd_out_t predict_gap(tsd_in_t w);
      int unsigned a;
      int unsigned b;
      int unsigned span;
      tsd_out_t    r;
      a = stamp_minutes(w.start_year, w.start_month, w.start_day, w.start_hour,
                        w.start_minute);
      b = stamp_minutes(w.stop_year, w.stop_month, w.stop_day, w.stop_hour,
                        w.stop_minute);
      span           = (b >= a) ? b - a : a - b;
      r.diff_days    = 16'(span / MinPerDay);
      r.diff_hours   = 5'((span % MinPerDay) / MinPerHour);
      r.diff_minutes = 6'(span % MinPerHour);
      return r;
    endfunction

    function void note_stamps(tsd_in_t w);
      pending_gaps.push_back(predict_gap(w));
    endfunction

    task report_mismatch(string msg);
      if (mismatch_count < PrintCap) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatch_count++;
    endtask

    task check_gap(tsd_out_t got);
      tsd_out_t want;
      if (pending_gaps.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d d %0d h %0d m",
                                  got.diff_days, got.diff_hours, got.diff_minutes));
        return;
      end
      want = pending_gaps.pop_front();
      if (got.diff_days !== want.diff_days) begin
        report_mismatch($sformatf("diff_days got %0d want %0d",
                                  got.diff_days, want.diff_days));
      end
      if (got.diff_hours !== want.diff_hours) begin
        report_mismatch($sformatf("diff_hours got %0d want %0d",
                                  got.diff_hours, want.diff_hours));
      end
      if (got.diff_minutes !== want.diff_minutes) begin
        report_mismatch($sformatf("diff_minutes got %0d want %0d",
                                  got.diff_minutes, want.diff_minutes));
      end
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tsd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tsd_out_t out_data_o;

  gap_scoreboard sb = new;

  // Idling controls of the sender and the receiver, and the watchdog's cycle count.
  bit          tx_quiet;
  bit          rx_quiet;
  bit          long_hold_req;
  int unsigned cycle_count;

  timestamp_difference_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Abort a hung run: no handshake may wait forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Pick an idle stretch: none when quiet, else mostly none, sometimes a few cycles, rarely a long one.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic tsd_in_t stamps(int unsigned y0, int unsigned m0, int unsigned d0,
                                     int unsigned h0, int unsigned mi0, int unsigned y1,
                                     int unsigned m1, int unsigned d1, int unsigned h1,
                                     int unsigned mi1);
    tsd_in_t w;
    w.start_year   = YearW'(y0);
    w.start_month  = MonthW'(m0);
    w.start_day    = DayW'(d0);
    w.start_hour   = HourW'(h0);
    w.start_minute = MinuteW'(mi0);
    w.stop_year    = YearW'(y1);
    w.stop_month   = MonthW'(m1);
    w.stop_day     = DayW'(d1);
    w.stop_hour    = HourW'(h1);
    w.stop_minute  = MinuteW'(mi1);
    return w;
  endfunction

  // Mostly pairs with in-range fields, some pairs on the same or next day,
  // and some raw bit patterns that reach every out-of-range field value.
  function automatic tsd_in_t random_stamps();
    int unsigned kind;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned h;
    logic [63:0] noise;
    kind  = $urandom_range(0, 9);
    y     = $urandom_range(0, 99);
    m     = $urandom_range(1, 12);
    d     = $urandom_range(1, 31);
    h     = $urandom_range(0, 23);
    noise = {$urandom, $urandom};
    if (kind < 6) begin
      return stamps(y, m, d, h, $urandom_range(0, 59),
                    $urandom_range(0, 99), $urandom_range(1, 12), $urandom_range(1, 31),
                    $urandom_range(0, 23), $urandom_range(0, 59));
    end
    if (kind < 8) begin
      return stamps(y, m, d, h, $urandom_range(0, 59),
                    y, m, d + $urandom_range(0, 1), $urandom_range(0, 23),
                    $urandom_range(0, 59));
    end
    return noise[$bits(tsd_in_t)-1:0];
  endfunction

  // Offer one word, hold it until accepted, then idle for the requested gap.
  // Keep valid high across back-to-back words so it is never lowered and
  // raised within one step.
  task automatic send_word(tsd_in_t w, int unsigned gap);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_stamps(w);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Pause the sender until every predicted result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_gaps.size() != 0);
  endtask

  // Receiver: check each accepted word, then choose the stall for the next edge.
  // The long hold-off is counted here, independent of the sender.
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_gap(out_data_o);
      end
      if (stall_left == 0) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          stall_left    = HoldCycles;
        end else begin
          stall_left = pick_gap(rx_quiet);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    rst_ni        = 1'b0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    long_hold_req = 1'b0;
    cycle_count   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, leap handling and out-of-range fields.
    send_word(stamps(0, 1, 1, 0, 0, 0, 1, 1, 0, 0), pick_gap(1'b0));         // equal stamps
    send_word(stamps(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), pick_gap(1'b0));         // all fields zero
    send_word(stamps(99, 12, 31, 23, 59, 0, 1, 1, 0, 0), pick_gap(1'b0));    // widest legal span
    send_word(stamps(0, 1, 1, 0, 0, 99, 12, 31, 23, 59), pick_gap(1'b0));    // same, swapped
    send_word(stamps(127, 15, 31, 31, 63, 0, 0, 0, 0, 0), pick_gap(1'b0));   // all ones vs zeros
    send_word(stamps(0, 0, 0, 0, 0, 127, 15, 31, 31, 63), pick_gap(1'b0));
    send_word(stamps(0, 2, 29, 0, 0, 0, 3, 1, 0, 0), pick_gap(1'b0));        // year zero is leap
    send_word(stamps(4, 2, 28, 12, 0, 4, 3, 1, 12, 0), pick_gap(1'b0));      // leap February
    send_word(stamps(100, 2, 28, 0, 0, 100, 3, 1, 0, 0), pick_gap(1'b0));    // century, not leap
    send_word(stamps(3, 2, 28, 0, 0, 3, 3, 1, 0, 0), pick_gap(1'b0));        // common February
    send_word(stamps(1, 2, 31, 0, 0, 1, 3, 1, 0, 0), pick_gap(1'b0));        // day past month end
    send_word(stamps(50, 0, 0, 0, 0, 50, 1, 1, 0, 0), pick_gap(1'b0));       // month and day zero
    send_word(stamps(20, 13, 5, 0, 0, 20, 14, 5, 0, 0), pick_gap(1'b0));     // months past twelve
    send_word(stamps(20, 15, 0, 0, 0, 21, 1, 0, 0, 0), pick_gap(1'b0));      // month 15 = full year
    send_word(stamps(10, 5, 5, 31, 63, 10, 5, 6, 0, 0), pick_gap(1'b0));     // hour/minute overrange
    send_word(stamps(101, 6, 15, 8, 30, 127, 6, 15, 8, 30), pick_gap(1'b0)); // years past 99
    send_word(stamps(99, 12, 31, 23, 59, 100, 1, 1, 0, 0), pick_gap(1'b0));  // one minute over
    send_word(stamps(0, 1, 1, 0, 0, 1, 1, 1, 0, 0), pick_gap(1'b0));         // year zero vs one
    send_word(stamps(7, 7, 7, 7, 7, 7, 7, 7, 7, 8), pick_gap(1'b0));
    send_word(stamps(7, 7, 7, 0, 0, 7, 7, 7, 23, 59), pick_gap(1'b0));
    drain();

    // Random phases: both sides idling, neither idling, a full-pipeline
    // hold-off with a steady receiver, then a steady sender.
    for (int p = 0; p < 4; p++) begin
      tx_quiet = (p == 1 || p == 3);
      rx_quiet = (p == 1 || p == 2);
      if (p == 2) begin
        long_hold_req = 1'b1;
        repeat (FillWords) send_word(random_stamps(), 0);
      end
      repeat (RandomWords / 4) send_word(random_stamps(), pick_gap(tx_quiet));
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending_gaps.size() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_gaps.size()));
    end
    if (sb.mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tsd_pkg.sv
rtl/tsd_count.sv
rtl/tsd_split.sv
rtl/timestamp_difference_core.sv
tb/tb_timestamp_difference_core.sv
